// ===== src/cws_pkg.sv =====
// Shared types and constants for the climate window statistics block.
// No dependencies; imported by cws_store, cws_divider and climate_window_stats.
package cws_pkg;

  typedef logic signed [10:0] temp_t;
  typedef logic        [9:0]  hum_t;

  // Sensor clamp limits
  localparam temp_t TEMP_LOW  = -11'sd400;
  localparam temp_t TEMP_HIGH = 11'sd850;
  localparam hum_t  HUM_HIGH  = 10'd1000;

  // Starting points for min and max searches
  localparam temp_t TEMP_MIN_INIT = 11'sd1023;
  localparam temp_t TEMP_MAX_INIT = -11'sd1024;
  localparam hum_t  HUM_MIN_INIT  = 10'd1023;
  localparam hum_t  HUM_MAX_INIT  = 10'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_TDIV_GO,
    S_TDIV_WAIT,
    S_HDIV_GO,
    S_HDIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== src/cws_store.sv =====
// Sample ring memory: one write port, one registered read port.
// Depends on cws_pkg for the sample types.
module cws_store #(
  parameter int DEPTH  = 300,
  parameter int ADDR_W = 9
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  cws_pkg::temp_t      wr_temp,
  input  cws_pkg::hum_t       wr_hum,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output cws_pkg::temp_t      rd_temp,
  output cws_pkg::hum_t       rd_hum
);
  import cws_pkg::*;

  logic [20:0] mem [DEPTH];

  // Write a clamped sample pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_temp, wr_hum};
    end
  end

  // Read one entry, data valid the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_temp, rd_hum} <= mem[rd_addr];
    end
  end

endmodule

// ===== src/cws_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by both means.
// Depends on cws_pkg for the status struct.
module cws_divider #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      dividend,
  input  logic [DEN_W-1:0]      divisor,
  output logic [NUM_W-1:0]      quotient,
  output cws_pkg::div_status_t  status
);
  import cws_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] steps;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem, quotient[NUM_W-1]};
    trial   = shifted - {1'b0, den};
    fits    = shifted >= {1'b0, den};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else if (start) begin
      steps <= CNT_W'(NUM_W);
      done  <= 1'b0;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
      done  <= (steps == CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // Datapath: remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (steps != '0) begin
      rem      <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

  assign status.busy = (steps != '0);
  assign status.done = done;

endmodule

// ===== src/climate_window_stats.sv =====
// Top level: sequencer, ring pointers, min/max/sum accumulator, output register.
// Depends on cws_pkg, cws_store and cws_divider.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------
//  in      | in_valid, in_ready, temp_tenths,         | one sample pair per beat
//          | humidity_tenths                          |
//  out     | out_valid, out_ready, stats_valid,       | one statistics beat per
//          | sample_count, temp_/humidity_ min,max,mean | input beat
//
// An input beat reads each of the N stored entries (N up to WINDOW) from memory,
// then runs two W-step divisions in the shared divider, W = 11 + clog2(WINDOW+1);
// an empty window goes straight to the result and skips both divisions.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next beat may be taken meanwhile.
// Reset clears pointers, fill count and handshake state; the ring needs no clear.
module climate_window_stats #(
  parameter int WINDOW = 300
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cws_pkg::temp_t temp_tenths,
  input  cws_pkg::hum_t  humidity_tenths,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           stats_valid,
  output logic [8:0]     sample_count,
  output cws_pkg::temp_t temp_min,
  output cws_pkg::temp_t temp_max,
  output cws_pkg::temp_t temp_mean,
  output cws_pkg::hum_t  humidity_min,
  output cws_pkg::hum_t  humidity_max,
  output cws_pkg::hum_t  humidity_mean
);
  import cws_pkg::*;

  localparam int ADDR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int TSUM_W = 11 + CNT_W;
  localparam int HSUM_W = 10 + CNT_W;

  state_t state, state_next;

  logic [ADDR_W-1:0] write_pointer;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  idx;
  logic              rd_live;

  logic              in_beat;
  logic              zero_pair;
  logic              wr_en;
  temp_t             wr_temp;
  hum_t              wr_hum;
  logic              rd_en;
  temp_t             rd_temp;
  hum_t              rd_hum;

  logic signed [TSUM_W-1:0] tsum;
  logic [HSUM_W-1:0]        hsum;
  temp_t                    tmin, tmax, tmean;
  hum_t                     hmin, hmax, hmean;

  logic              div_start;
  logic [TSUM_W-1:0] div_num;
  logic [TSUM_W-1:0] div_quo;
  div_status_t       div_sts;
  logic [TSUM_W-1:0] tmag;
  temp_t             tq;
  logic              load_out;
  logic              empty;

  assign in_beat   = in_valid && in_ready;
  assign zero_pair = (temp_tenths == '0) && (humidity_tenths == '0);
  assign wr_en     = in_beat && !zero_pair;
  assign empty     = (fill_count == '0);

  // Clamp the incoming pair to the sensor ranges
  always_comb begin
    wr_temp = temp_tenths;
    if (temp_tenths < TEMP_LOW) begin
      wr_temp = TEMP_LOW;
    end else if (temp_tenths > TEMP_HIGH) begin
      wr_temp = TEMP_HIGH;
    end
    wr_hum = (humidity_tenths > HUM_HIGH) ? HUM_HIGH : humidity_tenths;
  end

  cws_store #(
    .DEPTH  (WINDOW),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (write_pointer),
    .wr_temp (wr_temp),
    .wr_hum  (wr_hum),
    .rd_en   (rd_en),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_temp (rd_temp),
    .rd_hum  (rd_hum)
  );

  // Feed the divider the temperature magnitude, then the humidity sum
  assign tmag    = tsum[TSUM_W-1] ? TSUM_W'(-tsum) : TSUM_W'(tsum);
  assign div_num = (state == S_TDIV_GO) ? tmag : {1'b0, hsum};

  cws_divider #(
    .NUM_W (TSUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (fill_count),
    .quotient (div_quo),
    .status   (div_sts)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_SCAN;
      S_SCAN:      if (idx == fill_count) state_next = empty ? S_DONE : S_DRAIN;
      S_DRAIN:     state_next = S_TDIV_GO;
      S_TDIV_GO:   state_next = S_TDIV_WAIT;
      S_TDIV_WAIT: if (div_sts.done) state_next = S_HDIV_GO;
      S_HDIV_GO:   state_next = S_HDIV_WAIT;
      S_HDIV_WAIT: if (div_sts.done) state_next = S_DONE;
      S_DONE:      if (!out_valid || out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      S_IDLE:                 in_ready  = 1'b1;
      S_SCAN:                 rd_en     = (idx != fill_count);
      S_TDIV_GO, S_HDIV_GO:   div_start = 1'b1;
      S_DONE:                 load_out  = !out_valid || out_ready;
      default: ;
    endcase
  end

  // State, ring pointer, fill count, scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_pointer <= '0;
      fill_count    <= '0;
      idx           <= '0;
      rd_live       <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= rd_en;
      if (wr_en) begin
        write_pointer <= (write_pointer == ADDR_W'(WINDOW - 1)) ? '0
                                                                 : write_pointer + 1'b1;
        if (fill_count != CNT_W'(WINDOW)) begin
          fill_count <= fill_count + 1'b1;
        end
      end
      if (in_beat) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Accumulate sums and extremes over the entries read back
  always_ff @(posedge clk) begin
    if (in_beat) begin
      tsum <= '0;
      hsum <= '0;
      tmin <= TEMP_MIN_INIT;
      tmax <= TEMP_MAX_INIT;
      hmin <= HUM_MIN_INIT;
      hmax <= HUM_MAX_INIT;
    end else if (rd_live) begin
      tsum <= tsum + {{CNT_W{rd_temp[10]}}, rd_temp};
      hsum <= hsum + {{CNT_W{1'b0}}, rd_hum};
      if (rd_temp < tmin) tmin <= rd_temp;
      if (rd_temp > tmax) tmax <= rd_temp;
      if (rd_hum < hmin) hmin <= rd_hum;
      if (rd_hum > hmax) hmax <= rd_hum;
    end
  end

  // Capture the means; restore the temperature sign
  assign tq = temp_t'(div_quo[10:0]);
  always_ff @(posedge clk) begin
    if (state == S_TDIV_WAIT && div_sts.done) begin
      tmean <= tsum[TSUM_W-1] ? -tq : tq;
    end
    if (state == S_HDIV_WAIT && div_sts.done) begin
      hmean <= div_quo[9:0];
    end
  end

  // Output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; zeros when the window is empty
  always_ff @(posedge clk) begin
    if (load_out) begin
      stats_valid   <= !empty;
      sample_count  <= 9'(fill_count);
      temp_min      <= empty ? '0 : tmin;
      temp_max      <= empty ? '0 : tmax;
      temp_mean     <= empty ? '0 : tmean;
      humidity_min  <= empty ? '0 : hmin;
      humidity_max  <= empty ? '0 : hmax;
      humidity_mean <= empty ? '0 : hmean;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && fill_count != CNT_W'(WINDOW)) |=> fill_count == $past(fill_count) + 1'b1)
    else $error("fill count did not advance on a stored beat");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_TDIV_WAIT || state == S_HDIV_WAIT))
    else $error("divider finished outside a wait state");

  a_read_window: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> idx < fill_count)
    else $error("read beyond stored entries");
`endif

endmodule
